[rtl/hbin_pkg.sv]
// hbin_pkg: shared types, codes and helpers for the histogram bin accumulator.
// Used by hbin_div, hbin_ram and histogram_bin_accumulator_core. No dependencies.
package hbin_pkg;

    localparam int NBINS_DEFAULT = 4096;   // default bin store depth
    localparam int DATA_W        = 32;     // bin, sum and counter width
    localparam int X_W           = 32;     // input value width
    localparam int WEIGHT_W      = 16;     // fill weight width
    localparam int IDX_W         = 12;     // bin index width on the ports
    localparam int NB_W          = 13;     // n_bins register width
    localparam int QW            = NB_W;   // quotient bits (bin index < n_bins)
    localparam int DVD_W         = DATA_W + QW;
    localparam int PADDR_W       = 4;

    // request codes
    localparam logic [1:0] REQ_FILL  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // result status codes
    localparam logic [2:0] STAT_IN_RANGE = 3'd0;
    localparam logic [2:0] STAT_UNDER    = 3'd1;
    localparam logic [2:0] STAT_OVER     = 3'd2;
    localparam logic [2:0] STAT_READ     = 3'd3;
    localparam logic [2:0] STAT_CLEARED  = 3'd4;

    // configuration register indexes (paddr[3:2])
    localparam logic [1:0] CFG_N_BINS = 2'd0;
    localparam logic [1:0] CFG_X_MIN  = 2'd1;
    localparam logic [1:0] CFG_X_MAX  = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CLASS,
        S_CHECK,
        S_DIV,
        S_READ,
        S_UPDATE,
        S_FINISH
    } hbin_state_t;

    typedef struct packed {
        logic [1:0]              req_type;
        logic signed [X_W-1:0]   x;
        logic [WEIGHT_W-1:0]     weight;
        logic [IDX_W-1:0]        bin_addr;
    } hbin_in_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [IDX_W-1:0]  bin_index;
        logic [DATA_W-1:0] bin_value;
        logic [DATA_W-1:0] peak_value;
        logic [IDX_W-1:0]  peak_bin;
        logic [DATA_W-1:0] entry_total;
        logic [DATA_W-1:0] underflow_total;
        logic [DATA_W-1:0] overflow_total;
    } hbin_out_t;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [DATA_W-1:0] divisor;
    } hbin_div_req_t;

    typedef struct packed {
        logic          done;
        logic [QW-1:0] quotient;
    } hbin_div_rsp_t;

    function automatic logic [DATA_W-1:0] sat_add32(input logic [DATA_W-1:0] a,
                                                    input logic [DATA_W-1:0] b);
        logic [DATA_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[DATA_W] ? {DATA_W{1'b1}} : sum[DATA_W-1:0];
    endfunction

endpackage

[rtl/hbin_div.sv]
// hbin_div: restoring divider, one quotient bit per cycle.
// Depends on hbin_pkg. Requires dividend < divisor * 2**QW.
module hbin_div
    import hbin_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  hbin_div_req_t req,
    output hbin_div_rsp_t rsp
);

    localparam int CW = $clog2(QW);

    logic              busy_reg;
    logic              done_reg;
    logic [CW-1:0]     cnt_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] dsr_reg;
    logic [QW-1:0]     dvd_reg;
    logic [QW-1:0]     quo_reg;

    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;
    logic              ge;

    assign trial = {rem_reg, dvd_reg[QW-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(QW - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= req.dividend[DVD_W-1:QW];
            dvd_reg <= req.dividend[QW-1:0];
            dsr_reg <= req.divisor;
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
            dvd_reg <= {dvd_reg[QW-2:0], 1'b0};
            quo_reg <= {quo_reg[QW-2:0], ge};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[rtl/hbin_ram.sv]
// hbin_ram: bin store, one write port and one registered read port.
// Depends on hbin_pkg for the data width.
module hbin_ram
    import hbin_pkg::*;
#(
    parameter int DEPTH = NBINS_DEFAULT,
    parameter int AW    = $clog2(NBINS_DEFAULT)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/histogram_bin_accumulator_core.sv]
// Histogram bin accumulator: sequencer, counters and config port.
// Depends on hbin_pkg, hbin_div and hbin_ram.
//
// Usage:
//   s_valid/s_ready/s_data carry requests: fill (x, weight), read (bin_addr)
//   or clear. Every fill, read and clear gives one result transfer on
//   m_valid/m_ready/m_data; an unknown request code is taken and dropped.
//   Config (n_bins, x_min, x_max) is written through the APB port at
//   byte addresses 0, 4, 8 while the block is idle; pready is tied high.
// Steps from input transfer to m_valid, with the output slot free:
//   fill in range : classify (S_CLASS, S_CHECK), 13-step divider,
//                   bin store read and write-back
//   under/overflow: classify only       read: bin store read
//   clear         : one bin store entry zeroed per cycle, then the result
//   One request is in flight at a time; s_ready is high only when idle.
// Reset: counters and peak clear at once, then a clearing pass zeroes the
//   bin store with s_ready low. Config writes still work.
// Stall: a result waits in the output register; the next request is taken
//   meanwhile and holds in its final step until the register frees up.
module histogram_bin_accumulator_core
    import hbin_pkg::*;
#(
    parameter int NBINS = NBINS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    // request channel
    input  logic               s_valid,
    output logic               s_ready,
    input  hbin_in_t           s_data,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output hbin_out_t          m_data,
    // APB config port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IW = $clog2(NBINS);
    localparam logic [NB_W-1:0] NB_CLAMP = NB_W'((NBINS > 8191) ? 8191 : NBINS);
    localparam logic [IW-1:0]   CLR_LAST = IW'(NBINS - 1);

    // config registers
    logic [NB_W-1:0]        n_bins_reg;
    logic signed [X_W-1:0]  x_min_reg;
    logic signed [X_W-1:0]  x_max_reg;
    logic [NB_W-1:0]        n_use;
    logic                   cfg_wr;

    // sequencer
    hbin_state_t state_reg, state_next;

    // request and working registers
    logic [1:0]             req_reg;
    logic [WEIGHT_W-1:0]    w_reg;
    logic signed [X_W-1:0]  x_reg;
    logic [IDX_W-1:0]       addr_reg;
    logic [IW-1:0]          idx_reg;
    logic                   rd_ok_reg;
    logic [X_W:0]           off_reg;    // x - x_min, 33-bit signed
    logic [X_W:0]           dh_reg;     // x - x_max, 33-bit signed
    logic                   clr_req_reg;
    logic [IW-1:0]          clr_cnt_reg;

    // result holding
    logic [2:0]             res_status_reg;
    logic [IDX_W-1:0]       res_index_reg;
    logic [DATA_W-1:0]      res_value_reg;

    // counters
    logic [DATA_W-1:0]      under_reg;
    logic [DATA_W-1:0]      over_reg;
    logic [DATA_W-1:0]      entries_reg;
    logic [DATA_W-1:0]      peak_reg;
    logic [IW-1:0]          peak_idx_reg;

    // output register
    logic                   m_valid_reg;
    hbin_out_t              m_data_reg;

    // datapath
    logic                   in_range;
    logic [X_W:0]           span;
    logic [DVD_W-1:0]       prod;
    logic [DATA_W-1:0]      bin_sum;
    logic [DATA_W-1:0]      rdata;
    logic                   mem_we;
    logic [IW-1:0]          mem_waddr;
    logic [DATA_W-1:0]      mem_wdata;
    logic                   out_free;
    hbin_div_req_t          div_req;
    hbin_div_rsp_t          div_rsp;

    // ---------------- config port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_bins_reg <= NB_W'(4096);
            x_min_reg  <= '0;
            x_max_reg  <= X_W'(4096);
        end else if (cfg_wr) begin
            case (paddr[3:2])
                CFG_N_BINS: n_bins_reg <= pwdata[NB_W-1:0];
                CFG_X_MIN:  x_min_reg  <= pwdata;
                CFG_X_MAX:  x_max_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            CFG_N_BINS: prdata = {{(32-NB_W){1'b0}}, n_bins_reg};
            CFG_X_MIN:  prdata = x_min_reg;
            CFG_X_MAX:  prdata = x_max_reg;
            default:    prdata = '0;
        endcase
    end

    // bins in use: zero means one, clamp to store depth
    always_comb begin
        if (n_bins_reg == '0) begin
            n_use = NB_W'(1);
        end else if (32'(n_bins_reg) > 32'(NBINS)) begin
            n_use = NB_CLAMP;
        end else begin
            n_use = n_bins_reg;
        end
    end

    // ---------------- datapath helpers ----------------
    // in range: x >= x_min and x < x_max (both from 33-bit differences)
    assign in_range = !off_reg[X_W] && dh_reg[X_W];
    assign span     = off_reg - dh_reg;                  // x_max - x_min
    assign prod     = DVD_W'(off_reg[X_W-1:0]) * DVD_W'(n_use);
    assign bin_sum  = sat_add32(rdata, DATA_W'(w_reg));
    assign out_free = !m_valid_reg || m_ready;

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (clr_cnt_reg == CLR_LAST) begin
                    state_next = clr_req_reg ? S_FINISH : S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    case (s_data.req_type)
                        REQ_FILL:  state_next = S_CLASS;
                        REQ_READ:  state_next = S_READ;
                        REQ_CLEAR: state_next = S_CLEAR;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_CLASS:  state_next = S_CHECK;
            S_CHECK:  state_next = in_range ? S_DIV : S_FINISH;
            S_DIV: begin
                if (div_rsp.done) begin
                    state_next = S_READ;
                end
            end
            S_READ:   state_next = S_UPDATE;
            S_UPDATE: state_next = S_FINISH;
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // ---------------- sequencer outputs ----------------
    always_comb begin
        s_ready          = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = idx_reg;
        mem_wdata        = bin_sum;
        div_req.start    = 1'b0;
        div_req.dividend = prod;
        div_req.divisor  = span[DATA_W-1:0];
        case (state_reg)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
            end
            S_IDLE:   s_ready = 1'b1;
            S_CHECK:  div_req.start = in_range;
            S_UPDATE: mem_we = (req_reg == REQ_FILL);
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------- control and counters ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_req_reg  <= 1'b0;
            clr_cnt_reg  <= '0;
            under_reg    <= '0;
            over_reg     <= '0;
            entries_reg  <= '0;
            peak_reg     <= '0;
            peak_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            // in the final step the output register is refilled instead
            if (m_valid_reg && m_ready && state_reg != S_FINISH) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                end
                S_IDLE: begin
                    if (s_valid && s_data.req_type == REQ_CLEAR) begin
                        clr_req_reg  <= 1'b1;
                        clr_cnt_reg  <= '0;
                        under_reg    <= '0;
                        over_reg     <= '0;
                        entries_reg  <= '0;
                        peak_reg     <= '0;
                        peak_idx_reg <= '0;
                    end
                end
                S_CHECK: begin
                    if (off_reg[X_W]) begin
                        under_reg <= sat_add32(under_reg, DATA_W'(w_reg));
                    end else if (!dh_reg[X_W]) begin
                        over_reg <= sat_add32(over_reg, DATA_W'(w_reg));
                    end
                end
                S_UPDATE: begin
                    if (req_reg == REQ_FILL) begin
                        entries_reg <= sat_add32(entries_reg, DATA_W'(1));
                        if (bin_sum >= peak_reg) begin
                            peak_reg     <= bin_sum;
                            peak_idx_reg <= idx_reg;
                        end
                    end
                end
                S_FINISH: begin
                    clr_req_reg <= 1'b0;
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                req_reg        <= s_data.req_type;
                x_reg          <= s_data.x;
                w_reg          <= s_data.weight;
                addr_reg       <= s_data.bin_addr;
                idx_reg        <= IW'(s_data.bin_addr);
                rd_ok_reg      <= ({1'b0, s_data.bin_addr} < n_use);
                res_status_reg <= STAT_CLEARED;
                res_index_reg  <= '0;
                res_value_reg  <= '0;
            end
            S_CLASS: begin
                off_reg <= {x_reg[X_W-1], x_reg} - {x_min_reg[X_W-1], x_min_reg};
                dh_reg  <= {x_reg[X_W-1], x_reg} - {x_max_reg[X_W-1], x_max_reg};
            end
            S_CHECK: begin
                if (off_reg[X_W]) begin
                    res_status_reg <= STAT_UNDER;
                end else if (!dh_reg[X_W]) begin
                    res_status_reg <= STAT_OVER;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    idx_reg       <= IW'(div_rsp.quotient);
                    res_index_reg <= IDX_W'(div_rsp.quotient);
                end
            end
            S_UPDATE: begin
                if (req_reg == REQ_FILL) begin
                    res_status_reg <= STAT_IN_RANGE;
                    res_value_reg  <= bin_sum;
                end else begin
                    res_status_reg <= STAT_READ;
                    res_index_reg  <= addr_reg;
                    res_value_reg  <= rd_ok_reg ? rdata : '0;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    m_data_reg.status          <= res_status_reg;
                    m_data_reg.bin_index       <= res_index_reg;
                    m_data_reg.bin_value       <= res_value_reg;
                    m_data_reg.peak_value      <= peak_reg;
                    m_data_reg.peak_bin        <= IDX_W'(peak_idx_reg);
                    m_data_reg.entry_total     <= entries_reg;
                    m_data_reg.underflow_total <= under_reg;
                    m_data_reg.overflow_total  <= over_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------- submodules ----------------
    hbin_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    hbin_ram #(
        .DEPTH (NBINS),
        .AW    (IW)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (idx_reg),
        .rdata (rdata)
    );

`ifndef ASSERT_OFF
    // divider only finishes while the sequencer waits on it
    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == S_DIV)
        else $error("divider done outside divide step");

    // a filled bin never exceeds the reported peak
    a_peak_covers_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.status == STAT_IN_RANGE)
        |-> m_data_reg.peak_value >= m_data_reg.bin_value)
        else $error("peak below filled bin value");

    // clear result reports all counters zero
    a_clear_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.status == STAT_CLEARED)
        |-> (m_data_reg.entry_total == '0 && m_data_reg.underflow_total == '0 &&
             m_data_reg.overflow_total == '0 && m_data_reg.peak_value == '0))
        else $error("counters not zero after clear");

    // outside-range and clear results carry no bin
    a_no_bin_outside: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg.status == STAT_UNDER ||
                         m_data_reg.status == STAT_OVER ||
                         m_data_reg.status == STAT_CLEARED))
        |-> (m_data_reg.bin_index == '0 && m_data_reg.bin_value == '0))
        else $error("bin fields set on non-bin result");
`endif

endmodule
